/* rtl/core/dual_motor_pwm_straight_drive_top_defines.svh */
// Assertion helpers shared by the core files.
`ifndef DUAL_MOTOR_PWM_STRAIGHT_DRIVE_TOP_DEFINES_SVH
`define DUAL_MOTOR_PWM_STRAIGHT_DRIVE_TOP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define DMPSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dmpsd check failed");

// next-cycle implication
`define DMPSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dmpsd check failed");

`endif

/* rtl/core/dmpsd_pkg.sv */
package dmpsd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_INCH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_HUNDREDTHS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_STEP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DUTY      = 3'd4;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [15:0] RST_COUNTS_PER_INCH = 16'd1000;
    localparam logic [7:0]  RST_BIAS_HUNDREDTHS = 8'd102;
    localparam logic [4:0]  RST_DUTY_STEP       = 5'd3;
    localparam logic [6:0]  RST_PWM_PERIOD      = 7'd100;
    localparam logic [6:0]  RST_START_DUTY      = 7'd25;

    localparam logic [15:0] LEFT_SCALE = 16'd100;

    typedef struct packed {
        logic [15:0] counts_per_inch;
        logic [7:0]  bias_hundredths;
        logic [4:0]  duty_step;
        logic [6:0]  pwm_period;
        logic [6:0]  start_duty;
    } t_cfg;

    // one classified item; prod_a is dist*cpi on a start, left*100 on a tick
    typedef struct packed {
        logic        op;
        logic [31:0] left;
        logic [39:0] prod_a;
        logic [39:0] prod_r;
    } t_cmd;

    typedef struct packed {
        logic left_pwm;
        logic right_pwm;
        logic running;
        logic finished;
    } t_res;

endpackage

/* rtl/core/dmpsd_if.sv */
interface dmpsd_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [7:0]  distance_in;
    logic [31:0] left_count;
    logic [31:0] right_count;

    modport source (output valid, operation, distance_in, left_count, right_count,
                    input ready);
    modport sink   (input valid, operation, distance_in, left_count, right_count,
                    output ready);
endinterface

interface dmpsd_out_if;
    logic valid;
    logic ready;
    logic left_pwm;
    logic right_pwm;
    logic running;
    logic finished;

    modport source (output valid, left_pwm, right_pwm, running, finished, input ready);
    modport sink   (input valid, left_pwm, right_pwm, running, finished, output ready);
endinterface

interface dmpsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/dmpsd_front.sv */
module dmpsd_front
    import dmpsd_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  t_cfg          i_cfg_regs,
    dmpsd_in_if.sink      i_in,
    input  logic          i_full,
    output logic          o_push,
    output t_cmd          o_cmd
);

    localparam logic [63:0] MaskFull = (COUNT_WIDTH >= 64) ? '1 :
                                       ((64'd1 << COUNT_WIDTH) - 64'd1);
    localparam logic [31:0] CntMask  = MaskFull[31:0];

    logic [31:0] left_m;
    logic [31:0] right_m;
    logic [31:0] mul_x;
    logic [15:0] mul_y;
    logic [47:0] prod_a;
    logic [39:0] prod_r;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    assign left_m  = i_in.left_count & CntMask;
    assign right_m = i_in.right_count & CntMask;

    // one multiplier serves the target on a start and the left scale on a tick
    assign mul_x  = (i_in.operation == OP_START) ? {24'd0, i_in.distance_in} : left_m;
    assign mul_y  = (i_in.operation == OP_START) ? i_cfg_regs.counts_per_inch : LEFT_SCALE;
    assign prod_a = mul_x * mul_y;
    assign prod_r = right_m * {32'd0, i_cfg_regs.bias_hundredths};

    always_comb begin
        o_cmd.op     = i_in.operation;
        o_cmd.left   = left_m;
        o_cmd.prod_a = prod_a[39:0];
        o_cmd.prod_r = prod_r;
    end

endmodule

/* rtl/core/dmpsd_queue.sv */
module dmpsd_queue
    import dmpsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_wdata,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_rdata,
    output logic o_empty
);

    `include "dual_motor_pwm_straight_drive_top_defines.svh"

    t_cmd       r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr ^ i_push;
        n_rptr  = r_rptr ^ i_pop;
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    `DMPSD_ASSERT_NOW(a_pop_not_empty, i_pop, !o_empty)
    `DMPSD_ASSERT_NOW(a_push_not_full, i_push, !o_full)
    `DMPSD_ASSERT_NEXT(a_fill_grows, i_push && !i_pop, r_count == $past(r_count) + 2'd1)
    `DMPSD_ASSERT_NEXT(a_fill_drops, i_pop && !i_push, r_count == $past(r_count) - 2'd1)

endmodule

/* rtl/core/dmpsd_back.sv */
module dmpsd_back
    import dmpsd_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg_regs,
    input  t_cmd          i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    dmpsd_out_if.source   o_out
);

    `include "dual_motor_pwm_straight_drive_top_defines.svh"

    logic [6:0]              r_phase, n_phase;
    logic signed [8:0]       r_lduty, n_lduty;
    logic signed [8:0]       r_rduty, n_rduty;
    logic [COUNT_WIDTH-1:0]  r_target, n_target;
    logic                    r_active, n_active;
    logic                    r_ovalid;
    t_res                    r_res, n_res;

    logic signed [8:0] step_s;
    logic signed [8:0] top_s;
    logic signed [8:0] start_s;

    assign step_s  = $signed({4'd0, i_cfg_regs.duty_step});
    assign top_s   = $signed({2'd0, i_cfg_regs.pwm_period});
    assign start_s = $signed({2'd0, i_cfg_regs.start_duty});

    // the output register frees as it is read, so a transfer out and a pop share a cycle
    assign o_pop = !i_empty && (!r_ovalid || o_out.ready);

    always_comb begin
        logic [64:0] sum;
        logic [7:0]  phase_inc;
        logic        lpwm;
        logic        rpwm;
        n_phase  = r_phase;
        n_lduty  = r_lduty;
        n_rduty  = r_rduty;
        n_target = r_target;
        n_active = r_active;
        n_res    = '0;
        sum       = 65'(i_cmd.left) + 65'(i_cmd.prod_a[23:0]);
        phase_inc = {1'b0, r_phase} + 8'd1;
        lpwm      = 1'b0;
        rpwm      = 1'b0;
        if (o_pop) begin
            if (i_cmd.op == OP_START) begin
                n_target    = sum[COUNT_WIDTH-1:0];
                n_lduty     = start_s;
                n_rduty     = start_s;
                n_phase     = '0;
                n_active    = 1'b1;
                n_res.running = 1'b1;
            end else if (r_active) begin
                if (phase_inc >= {1'b0, i_cfg_regs.pwm_period}) begin
                    n_phase = '0;
                end else begin
                    n_phase = phase_inc[6:0];
                end
                lpwm = $signed({2'd0, n_phase}) < r_lduty;
                rpwm = $signed({2'd0, n_phase}) < r_rduty;
                if (i_cmd.prod_r < i_cmd.prod_a) begin
                    // right behind
                    if (r_rduty < top_s) n_rduty = r_rduty + step_s;
                    if (r_lduty > 9'sd0) n_lduty = r_lduty - step_s;
                end else if (i_cmd.prod_a < i_cmd.prod_r) begin
                    if (r_lduty < top_s) n_lduty = r_lduty + step_s;
                    if (r_rduty > 9'sd0) n_rduty = r_rduty - step_s;
                end
                if (64'(i_cmd.left) < 64'(r_target)) begin
                    n_res.left_pwm  = lpwm;
                    n_res.right_pwm = rpwm;
                    n_res.running   = 1'b1;
                end else begin
                    n_active       = 1'b0;
                    n_res.finished = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_lduty  <= $signed({2'd0, RST_START_DUTY});
            r_rduty  <= $signed({2'd0, RST_START_DUTY});
            r_target <= '0;
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_lduty  <= n_lduty;
            r_rduty  <= n_rduty;
            r_target <= n_target;
            r_active <= n_active;
            if (o_pop) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.left_pwm  = r_res.left_pwm;
    assign o_out.right_pwm = r_res.right_pwm;
    assign o_out.running   = r_res.running;
    assign o_out.finished  = r_res.finished;

    `DMPSD_ASSERT_NOW(a_run_xor_done, r_ovalid, !(r_res.running && r_res.finished))
    `DMPSD_ASSERT_NEXT(a_running_means_active, o_pop && n_res.running, r_active)
    `DMPSD_ASSERT_NEXT(a_start_loads_duty, o_pop && (i_cmd.op == OP_START),
                       (r_lduty == $past(start_s)) && (r_rduty == $past(start_s)))
    `DMPSD_ASSERT_NOW(a_idle_pwm_low, o_pop && !r_active, !n_res.left_pwm && !n_res.right_pwm)

endmodule

/* rtl/core/dual_motor_pwm_straight_drive_top.sv */
// Straight-line drive controller for a pair of motors.
// Input channel i_in: a start item (operation 0) latches target = left_count +
// distance_in * counts_per_inch, reloads both duties and sets running; a tick
// item (operation 1) in a run steps the PWM phase, gives both PWM levels and
// trims the duties towards straight travel, comparing right_count * bias/100
// with left_count, and once left_count reaches the target ends the run with
// finished. Every item gives exactly one result on o_out. Config channel
// i_cfg: index 0..4 selects counts_per_inch, bias_hundredths, duty_step,
// pwm_period, start_duty; it is always ready. The user must write it only
// while no item is in flight; the block itself does not enforce this.
// Path: the front multipliers feed a two-entry queue, then the steering unit
// loads the output register, which drives o_out.valid.
// Throughput is one item per cycle while o_out.ready stays high; the steering
// update of the duties, which each tick depends on, is registered as it pops.
// Reset (synchronous, active low) loads the default register values, clears
// the queue and the output register and leaves the drive idle.
// When the receiver stalls, the result holds, the queue fills and i_in.ready
// drops once two items are waiting.
module dual_motor_pwm_straight_drive_top
    import dmpsd_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dmpsd_cfg_if.sink     i_cfg,
    dmpsd_in_if.sink      i_in,
    dmpsd_out_if.source   o_out
);

    t_cfg r_cfg;
    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.counts_per_inch <= RST_COUNTS_PER_INCH;
            r_cfg.bias_hundredths <= RST_BIAS_HUNDREDTHS;
            r_cfg.duty_step       <= RST_DUTY_STEP;
            r_cfg.pwm_period      <= RST_PWM_PERIOD;
            r_cfg.start_duty      <= RST_START_DUTY;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_COUNTS_PER_INCH: r_cfg.counts_per_inch <= i_cfg.data;
                CFG_BIAS_HUNDREDTHS: r_cfg.bias_hundredths <= i_cfg.data[7:0];
                CFG_DUTY_STEP:       r_cfg.duty_step       <= i_cfg.data[4:0];
                CFG_PWM_PERIOD:      r_cfg.pwm_period      <= i_cfg.data[6:0];
                CFG_START_DUTY:      r_cfg.start_duty      <= i_cfg.data[6:0];
                default: ;
            endcase
        end
    end

    dmpsd_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_cfg_regs (r_cfg),
        .i_in       (i_in),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    dmpsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_rdata (head_cmd),
        .o_empty (empty)
    );

    dmpsd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_regs (r_cfg),
        .i_cmd      (head_cmd),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule
